FILE: rtl/metadata_piece_tracker_macros.svh
// ----------------------------------------------------------------------------
// Metadata piece tracker assertion macros
// Shared assertion forms for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef METADATA_PIECE_TRACKER_MACROS_SVH
`define METADATA_PIECE_TRACKER_MACROS_SVH

// same-cycle implication
`define MPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mpt_pkg.sv
// ----------------------------------------------------------------------------
// Metadata piece tracker package
// Constants, codes and piece length helper.
// ----------------------------------------------------------------------------
package mpt_pkg;

    localparam int MAX_PIECES_DEF = 64;
    localparam int PIECE_SHIFT    = 14;
    localparam int PIECE_SIZE     = 1 << PIECE_SHIFT;
    localparam int SIZE_W         = 24;
    localparam int NUM_W          = 16;
    localparam int TIME_W         = 32;
    localparam int CNT_W          = SIZE_W - PIECE_SHIFT + 1;
    localparam int LEN_W          = 17;

    localparam logic [1:0] KIND_SIZE    = 2'd0;
    localparam logic [1:0] KIND_PIECE   = 2'd1;
    localparam logic [1:0] KIND_REQUEST = 2'd2;

    typedef enum logic [3:0] {
        ST_ACCEPTED     = 4'd0,
        ST_REQ_GIVEN    = 4'd1,
        ST_NONE_NEEDED  = 4'd2,
        ST_STARTED      = 4'd3,
        ST_RESTARTED    = 4'd4,
        ST_RETUNED      = 4'd5,
        ST_UNCHANGED    = 4'd6,
        ST_INCOMPATIBLE = 4'd7,
        ST_INVALID_SIZE = 4'd8,
        ST_NOT_STARTED  = 4'd9,
        ST_OUT_OF_RANGE = 4'd10,
        ST_BAD_LENGTH   = 4'd11,
        ST_DUPLICATE    = 4'd12
    } status_t;

    function automatic logic [CNT_W-1:0] count_for_size(input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0] sum;
        sum = {1'b0, size} + (SIZE_W+1)'(PIECE_SIZE - 1);
        return CNT_W'(sum >> PIECE_SHIFT);
    endfunction

    function automatic logic [LEN_W-1:0] bytes_at_piece(input logic [SIZE_W-1:0] size,
                                                        input logic [NUM_W-1:0] idx);
        logic [CNT_W:0]         last;
        logic [PIECE_SHIFT-1:0] rem;
        last = (CNT_W+1)'(count_for_size(size)) - (CNT_W+1)'(1);
        rem  = size[PIECE_SHIFT-1:0];
        if ((NUM_W+1)'(idx) == (NUM_W+1)'(last) && rem != '0)
            return LEN_W'(rem);
        return LEN_W'(PIECE_SIZE);
    endfunction

endpackage

FILE: rtl/metadata_piece_tracker.sv
// ----------------------------------------------------------------------------
// Metadata piece tracker
// Tracks needed metadata pieces and picks the next piece to request.
// ----------------------------------------------------------------------------
// One item at a time. Size items that need no retune check, piece items,
// requests while idle and unused kinds go straight to the result step. A
// retune check walks every piece entry through one compare unit. A
// next-piece request while tracking walks the time stamp RAM one entry per
// cycle through one compare unit. A result that is not taken holds the block
// in its last step.
`include "metadata_piece_tracker_macros.svh"

module metadata_piece_tracker #(
    parameter int MAX_PIECES = mpt_pkg::MAX_PIECES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // size_bytes[23:0], piece_number[39:24], piece_bytes[55:40], now_time[87:56]
    input  logic [87:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // request_piece[5:0], pieces_done[12:6], pieces_total[19:13], zero[23:20]
    output logic [23:0] m_axis_tdata,
    // status[3:0]
    output logic [3:0]  m_axis_tuser,
    // all_complete
    output logic        m_axis_tlast
);

    import mpt_pkg::*;

    localparam int IW   = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int CW   = $clog2(MAX_PIECES + 1);
    localparam int CMPW = 17;
    localparam logic [SIZE_W:0] SIZE_LIMIT = (SIZE_W+1)'(MAX_PIECES * PIECE_SIZE);

    typedef enum logic [1:0] { S_IDLE, S_FIT, S_SCAN, S_FIN } state_t;

    state_t                 state_reg, state_next;
    logic                   active_reg, active_next;
    logic [SIZE_W-1:0]      cur_size_reg, cur_size_next;
    logic [CW-1:0]          total_reg, total_next;
    logic [CW-1:0]          done_reg, done_next;
    logic [MAX_PIECES-1:0]  need_reg, need_next;
    logic [MAX_PIECES-1:0]  stamp_vld_reg, stamp_vld_next;
    logic [SIZE_W-1:0]      new_size_reg, new_size_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                   found_reg, found_next;
    logic [IW-1:0]          best_reg, best_next;
    logic [TIME_W-1:0]      best_val_reg, best_val_next;
    logic                   fail_reg, fail_next;
    status_t                res_status_reg, res_status_next;
    logic [IW-1:0]          res_req_reg, res_req_next;
    logic                   res_cmpl_reg, res_cmpl_next;
    logic                   m_valid_reg, m_valid_next;
    logic [23:0]            m_data_reg, m_data_next;
    logic [3:0]             m_user_reg, m_user_next;
    logic                   m_last_reg, m_last_next;

    logic                   ram_we;
    logic [TIME_W-1:0]      ram_rdata;
    logic [IW-1:0]          walk_idx;
    logic [SIZE_W-1:0]      in_size;
    logic [NUM_W-1:0]       in_num;
    logic [NUM_W-1:0]       in_len;
    logic [CNT_W-1:0]       in_count;
    logic [CNT_W-1:0]       new_count;
    logic                   fail_now;
    logic [TIME_W-1:0]      cand_val;

    assign walk_idx  = idx_reg[IW-1:0];
    assign in_size   = s_axis_tdata[23:0];
    assign in_num    = s_axis_tdata[39:24];
    assign in_len    = s_axis_tdata[55:40];
    assign in_count  = count_for_size(in_size);
    assign new_count = count_for_size(new_size_reg);
    assign cand_val  = stamp_vld_reg[cmp_idx_reg] ? ram_rdata : '0;

    always_comb
    begin
        fail_now = 1'b0;
        if (CMPW'(idx_reg) < CMPW'(total_reg) && !need_reg[walk_idx])
        begin
            if (CMPW'(idx_reg) >= CMPW'(new_count) ||
                bytes_at_piece(cur_size_reg, NUM_W'(idx_reg)) !=
                bytes_at_piece(new_size_reg, NUM_W'(idx_reg)))
            begin
                fail_now = 1'b1;
            end
        end
    end

    mpt_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_PIECES)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (best_reg),
        .wdata (now_reg),
        .raddr (walk_idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        cur_size_next   = cur_size_reg;
        total_next      = total_reg;
        done_next       = done_reg;
        need_next       = need_reg;
        stamp_vld_next  = stamp_vld_reg;
        new_size_next   = new_size_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_val_next   = best_val_reg;
        fail_next       = fail_reg;
        res_status_next = res_status_reg;
        res_req_next    = res_req_reg;
        res_cmpl_next   = res_cmpl_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next    = S_FIN;
                    res_req_next  = '0;
                    res_cmpl_next = 1'b0;
                    unique case (s_axis_tuser)
                        KIND_SIZE:
                        begin
                            if (in_size == '0 || {1'b0, in_size} > SIZE_LIMIT)
                            begin
                                res_status_next = ST_INVALID_SIZE;
                            end
                            else if (active_reg && in_size == cur_size_reg)
                            begin
                                res_status_next = ST_UNCHANGED;
                            end
                            else if (active_reg && done_reg != '0)
                            begin
                                new_size_next = in_size;
                                idx_next      = '0;
                                fail_next     = 1'b0;
                                state_next    = S_FIT;
                            end
                            else
                            begin
                                res_status_next = active_reg ? ST_RESTARTED : ST_STARTED;
                                active_next     = 1'b1;
                                cur_size_next   = in_size;
                                total_next      = CW'(in_count);
                                done_next       = '0;
                                stamp_vld_next  = '0;
                                for (int i = 0; i < MAX_PIECES; i++)
                                begin
                                    need_next[i] = (CMPW'(i) < CMPW'(in_count));
                                end
                            end
                        end
                        KIND_PIECE:
                        begin
                            if (!active_reg)
                            begin
                                res_status_next = ST_NOT_STARTED;
                            end
                            else if (CMPW'(in_num) >= CMPW'(total_reg))
                            begin
                                res_status_next = ST_OUT_OF_RANGE;
                            end
                            else if (LEN_W'(in_len) != bytes_at_piece(cur_size_reg, in_num))
                            begin
                                res_status_next = ST_BAD_LENGTH;
                            end
                            else if (!need_reg[in_num[IW-1:0]])
                            begin
                                res_status_next = ST_DUPLICATE;
                            end
                            else
                            begin
                                res_status_next             = ST_ACCEPTED;
                                need_next[in_num[IW-1:0]]   = 1'b0;
                                done_next                   = done_reg + CW'(1);
                                res_cmpl_next = (done_reg + CW'(1) == total_reg);
                            end
                        end
                        KIND_REQUEST:
                        begin
                            res_status_next = ST_NONE_NEEDED;
                            if (active_reg)
                            begin
                                now_next     = s_axis_tdata[87:56];
                                idx_next     = '0;
                                cmp_vld_next = 1'b0;
                                found_next   = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OUT_OF_RANGE;
                        end
                    endcase
                end
            end
            S_FIT:
            begin
                if (CMPW'(idx_reg) == CMPW'(MAX_PIECES))
                begin
                    state_next = S_FIN;
                    if (fail_reg)
                    begin
                        res_status_next = ST_INCOMPATIBLE;
                    end
                    else
                    begin
                        res_status_next = ST_RETUNED;
                        cur_size_next   = new_size_reg;
                        total_next      = CW'(new_count);
                        stamp_vld_next  = '0;
                        for (int i = 0; i < MAX_PIECES; i++)
                        begin
                            need_next[i] = (CMPW'(i) < CMPW'(new_count)) &&
                                !((CMPW'(i) < CMPW'(total_reg)) && !need_reg[i]);
                        end
                    end
                end
                else
                begin
                    fail_next = fail_reg | fail_now;
                    idx_next  = idx_reg + CW'(1);
                end
            end
            S_SCAN:
            begin
                if (cmp_vld_reg && CMPW'(cmp_idx_reg) < CMPW'(total_reg) &&
                    need_reg[cmp_idx_reg] && (!found_reg || cand_val < best_val_reg))
                begin
                    found_next    = 1'b1;
                    best_next     = cmp_idx_reg;
                    best_val_next = cand_val;
                end
                if (CMPW'(idx_reg) < CMPW'(MAX_PIECES))
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = walk_idx;
                    idx_next     = idx_reg + CW'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    if (!cmp_vld_reg)
                    begin
                        state_next = S_FIN;
                        if (found_reg)
                        begin
                            ram_we                   = 1'b1;
                            stamp_vld_next[best_reg] = 1'b1;
                            res_status_next          = ST_REQ_GIVEN;
                            res_req_next             = best_reg;
                        end
                    end
                end
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_last_next  = res_cmpl_reg;
                    m_data_next  = {4'd0, 7'(total_reg), 7'(done_reg), 6'(res_req_reg)};
                    state_next   = S_IDLE;
                    if (res_cmpl_reg)
                    begin
                        active_next    = 1'b0;
                        cur_size_next  = '0;
                        total_next     = '0;
                        done_next      = '0;
                        need_next      = '0;
                        stamp_vld_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            cur_size_reg  <= '0;
            total_reg     <= '0;
            done_reg      <= '0;
            need_reg      <= '0;
            stamp_vld_reg <= '0;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            fail_reg      <= 1'b0;
            res_cmpl_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            cur_size_reg  <= cur_size_next;
            total_reg     <= total_next;
            done_reg      <= done_next;
            need_reg      <= need_next;
            stamp_vld_reg <= stamp_vld_next;
            idx_reg       <= idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            fail_reg      <= fail_next;
            res_cmpl_reg  <= res_cmpl_next;
            m_valid_reg   <= m_valid_next;
            m_last_reg    <= m_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_size_reg   <= new_size_next;
        now_reg        <= now_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_reg       <= best_next;
        best_val_reg   <= best_val_next;
        res_status_reg <= res_status_next;
        res_req_reg    <= res_req_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    `MPT_ASSERT_NOW(a_done_le_total, 1'b1, done_reg <= total_reg, "done count exceeds total")
    `MPT_ASSERT_NOW(a_req_in_range, m_axis_tvalid && m_axis_tuser == ST_REQ_GIVEN,
        m_axis_tdata[5:0] < m_axis_tdata[19:13], "requested piece beyond total")
    `MPT_ASSERT_NOW(a_cmpl_counts, m_axis_tvalid && m_axis_tlast,
        m_axis_tuser == ST_ACCEPTED && m_axis_tdata[12:6] == m_axis_tdata[19:13],
        "completion with mismatched counts")
    `MPT_ASSERT_NOW(a_cmpl_idle, $rose(m_axis_tvalid) && m_axis_tlast, !active_reg,
        "tracker still active after completion")
    `MPT_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "second request taken before result")

endmodule

FILE: rtl/mpt_ram.sv
// ----------------------------------------------------------------------------
// Metadata piece tracker RAM
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module mpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
